// File: hw/rtl/assert_macros.svh
// assertion macros shared by the state history ring modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define SHR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define SHR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define SHR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SHR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/shr_pkg.sv
// types and constants for the state history ring
`timescale 1ns / 1ps
package shr_pkg;

   localparam int STATE_W = 8;
   localparam int DUR_W   = 14;
   localparam int OFF_W   = 8;

   localparam logic [DUR_W-1:0] DUR_MAX = 14'd9999;

   // item kinds carried on tuser
   typedef enum logic [1:0] {
      KIND_OBSERVE = 2'd0,
      KIND_TICK    = 2'd1,
      KIND_CLEAR   = 2'd2
   } kind_type;

   // register indexes (byte address is four times the index)
   localparam logic REG_DWELL_THRESHOLD = 1'b0;
   localparam logic REG_INITIAL_STATE   = 1'b1;

   // update command broadcast to every cell
   typedef struct packed {
      logic shift;
      logic write_head;
      logic tick;
      logic clear;
   } cell_ctrl_type;

   // read wave travelling along the row of cells
   typedef struct packed {
      logic               valid;
      logic               found;
      logic [STATE_W-1:0] state;
      logic [DUR_W-1:0]   dur;
   } probe_type;

endpackage

// File: hw/rtl/state_history_ring_with_dwell.sv
// top level of the state history ring with dwell times
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The history is a row of DEPTH cells with the newest entry in cell 0; opening a new
// entry shifts every cell one place along, so the oldest entry drops off the far end.
// Observe, tick and clear are applied at the edge that accepts the item. The report is
// then fetched by a read wave that walks the row one cell per cycle, from a launch
// register through every cell into a holding slot and then the output register, and the
// next item is taken at the edge after the result has moved into the output register.
// A finished result may wait on rsp_tready while the next item is already being worked.
module state_history_ring_with_dwell #(
   parameter int DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] state_code, [15:8] back_offset
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] reported_state, [21:8] reported_duration
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import shr_pkg::*;

   localparam int CW = $clog2(DEPTH);

   // registers
   logic [DUR_W-1:0]   thr_ff;
   logic [STATE_W-1:0] init_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= 14'd5;
         init_ff <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_DWELL_THRESHOLD: thr_ff  <= csr_pwdata[DUR_W-1:0];
            REG_INITIAL_STATE:   init_ff <= csr_pwdata[STATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_DWELL_THRESHOLD: csr_prdata = {{(32-DUR_W){1'b0}}, thr_ff};
         REG_INITIAL_STATE:   csr_prdata = {{(32-STATE_W){1'b0}}, init_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // request fields
   logic [STATE_W-1:0] req_code;
   logic [OFF_W-1:0]   req_off;
   logic               req_acc;
   logic               busy_ff;
   logic [CW-1:0]      off_eff;

   assign req_code   = req_tdata[7:0];
   assign req_off    = req_tdata[15:8];
   assign req_tready = !busy_ff;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      if (32'(req_off) >= DEPTH) off_eff = '0;
      else                       off_eff = req_off[CW-1:0];
   end

   // row of cells
   logic [STATE_W-1:0] st   [DEPTH];
   logic [DUR_W-1:0]   dur  [DEPTH];
   probe_type          pr   [DEPTH+1];
   logic [CW-1:0]      rem  [DEPTH+1];
   cell_ctrl_type      ctrl;

   // update command from the head entry and the item kind
   always_comb begin
      ctrl = '0;
      if (req_acc) begin
         case (kind_type'(req_tuser))
            KIND_OBSERVE: begin
               if (req_code != st[0]) begin
                  if (dur[0] > thr_ff) ctrl.shift      = 1'b1;
                  else                 ctrl.write_head = 1'b1;
               end
            end
            KIND_TICK:  ctrl.tick  = 1'b1;
            KIND_CLEAR: ctrl.clear = 1'b1;
            default: ;
         endcase
      end
   end

   // read wave launch, entering cell 0 after the update has landed
   probe_type     inject_ff;
   logic [CW-1:0] inject_rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inject_ff <= '0;
      end else begin
         inject_ff <= '{valid: req_acc, found: 1'b0, state: '0, dur: '0};
      end
      inject_rem_ff <= off_eff;
   end

   assign pr[0]  = inject_ff;
   assign rem[0] = inject_rem_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [STATE_W-1:0] prev_state;
      logic [DUR_W-1:0]   prev_dur;

      if (i == 0) begin : g_head
         assign prev_state = req_code;
         assign prev_dur   = '0;
      end else begin : g_body
         assign prev_state = st[i-1];
         assign prev_dur   = dur[i-1];
      end

      shr_cell #(
         .HEAD (i == 0),
         .CW   (CW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .init_state (init_ff),
         .prev_state (prev_state),
         .prev_dur   (prev_dur),
         .state_out  (st[i]),
         .dur_out    (dur[i]),
         .probe_in   (pr[i]),
         .rem_in     (rem[i]),
         .probe_out  (pr[i+1]),
         .rem_out    (rem[i+1])
      );
   end

   // wave exit into a holding slot, then into the output register
   probe_type          pend_ff;
   logic               rsp_valid_ff;
   logic [STATE_W-1:0] rsp_state_ff;
   logic [DUR_W-1:0]   rsp_dur_ff;
   logic               rsp_load;

   assign rsp_load = pend_ff.valid && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pr[DEPTH].valid) pend_ff <= pr[DEPTH];
         else if (rsp_load)   pend_ff.valid <= 1'b0;

         if (req_acc)       busy_ff <= 1'b1;
         else if (rsp_load) busy_ff <= 1'b0;

         if (rsp_load)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_state_ff <= pend_ff.state;
         rsp_dur_ff   <= pend_ff.dur;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24-STATE_W-DUR_W){1'b0}}, rsp_dur_ff, rsp_state_ff};

   // checks
   `SHR_ASSERT_NEXT(a_accept_sets_busy, clock, reset, req_acc, busy_ff)
   `SHR_ASSERT_IMP(a_pend_while_busy, clock, reset, pend_ff.valid, busy_ff)
   `SHR_ASSERT_IMP(a_exit_found, clock, reset, pr[DEPTH].valid,
      pr[DEPTH].found && busy_ff && !pend_ff.valid)
   `SHR_ASSERT_IMP(a_single_update, clock, reset, 1'b1,
      $onehot0({ctrl.shift, ctrl.write_head, ctrl.tick, ctrl.clear}))

endmodule

// File: hw/rtl/shr_cell.sv
// one ring entry: state code, dwell count and one stage of the read wave
`timescale 1ns / 1ps
`include "assert_macros.svh"
module shr_cell #(
   parameter bit HEAD = 1'b0,
   parameter int CW   = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  shr_pkg::cell_ctrl_type        ctrl,
   input  logic [shr_pkg::STATE_W-1:0]   init_state,
   input  logic [shr_pkg::STATE_W-1:0]   prev_state,
   input  logic [shr_pkg::DUR_W-1:0]     prev_dur,
   output logic [shr_pkg::STATE_W-1:0]   state_out,
   output logic [shr_pkg::DUR_W-1:0]     dur_out,
   input  shr_pkg::probe_type            probe_in,
   input  logic [CW-1:0]                 rem_in,
   output shr_pkg::probe_type            probe_out,
   output logic [CW-1:0]                 rem_out
);
   import shr_pkg::*;

   logic [STATE_W-1:0] state_ff, state_in;
   logic [DUR_W-1:0]   dur_ff, dur_in;
   probe_type          probe_ff, probe_in_nx;
   logic [CW-1:0]      rem_ff, rem_nx;

   // entry update
   always_comb begin
      state_in = state_ff;
      dur_in   = dur_ff;
      if (ctrl.clear) begin
         state_in = init_state;
         dur_in   = '0;
      end else if (ctrl.shift || (HEAD && ctrl.write_head)) begin
         state_in = prev_state;
         dur_in   = prev_dur;
      end else if (HEAD && ctrl.tick && (dur_ff < DUR_MAX)) begin
         dur_in = dur_ff + DUR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         dur_ff   <= '0;
      end else begin
         state_ff <= state_in;
         dur_ff   <= dur_in;
      end
   end

   assign state_out = state_ff;
   assign dur_out   = dur_ff;

   // read wave: the cell whose countdown reaches zero drops its entry in
   always_comb begin
      probe_in_nx = probe_in;
      rem_nx      = rem_in - CW'(1);
      if (probe_in.valid && !probe_in.found && (rem_in == '0)) begin
         probe_in_nx.found = 1'b1;
         probe_in_nx.state = state_ff;
         probe_in_nx.dur   = dur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_nx;
      end
      rem_ff <= rem_nx;
   end

   assign probe_out = probe_ff;
   assign rem_out   = rem_ff;

   // checks
   `SHR_ASSERT_IMP(a_dur_saturates, clock, reset, 1'b1, dur_ff <= DUR_MAX)
   `SHR_ASSERT_IMP(a_found_needs_valid, clock, reset, probe_ff.found, probe_ff.valid)
   `SHR_ASSERT_NEXT(a_hit_captured, clock, reset,
      probe_in.valid && !probe_in.found && (rem_in == '0), probe_ff.found)

endmodule
